### rtl/pie_pkg.sv
package pie_pkg;

  // Sizes of the point store and number format
  localparam int MAX_POINTS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int DATA_W     = 32;
  localparam int EVAL_W     = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int PROD_W     = 2 * DATA_W;
  localparam int DEN_W      = DATA_W + 1;
  localparam int DIV_STEPS  = PROD_W;
  localparam int DCNT_W     = $clog2(DIV_STEPS);

  // Result status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_OK  = 2'd0;
  localparam status_t ST_DUP = 2'd1;
  localparam status_t ST_SAT = 2'd2;
  localparam status_t ST_OVF = 2'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic             load;
    logic [IDX_W-1:0] load_addr;
    logic [IDX_W-1:0] idx_i;
    logic [IDX_W-1:0] idx_j;
    logic             clr_sat;
    logic             do_sub;
    logic             do_mul;
    logic             do_num;
    logic             div_load;
    logic             div_step;
    logic             wr_p;
    logic             cap_out;
    status_t          out_code;
  } pie_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic den_zero;
  } pie_sts_t;

endpackage

### rtl/pie_dp.sv
module pie_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_wr,
  input  logic signed [pie_pkg::EVAL_W-1:0]      cfg_eval_point,
  input  logic signed [pie_pkg::DATA_W-1:0]      in_point_x,
  input  logic signed [pie_pkg::DATA_W-1:0]      in_point_y,
  input  pie_pkg::pie_cmd_t                      cmd,
  output pie_pkg::pie_sts_t                      sts,
  output logic signed [pie_pkg::DATA_W-1:0]      out_value,
  output pie_pkg::status_t                       out_status
);

  localparam int DW = pie_pkg::DATA_W;
  localparam int PW = pie_pkg::PROD_W;
  localparam int NW = PW + 1;
  localparam int EW = pie_pkg::EVAL_W;
  localparam int QW = pie_pkg::DEN_W;
  localparam logic signed [PW-1:0] D_MAX = (PW'(1) <<< (DW - 1)) - PW'(1);
  localparam logic signed [PW-1:0] D_MIN = -(PW'(1) <<< (DW - 1));
  localparam logic signed [NW-1:0] N_MAX = (NW'(1) <<< (PW - 1)) - NW'(1);
  localparam logic signed [NW-1:0] N_MIN = -N_MAX;
  localparam logic [PW-1:0]        Q_POS = (PW'(1) <<< (DW - 1)) - PW'(1);
  localparam logic [PW-1:0]        Q_NEG = PW'(1) <<< (DW - 1);

  logic signed [EW-1:0]  eval_point_r;
  logic signed [DW-1:0]  x_mem [pie_pkg::MAX_POINTS];
  logic signed [DW-1:0]  p_mem [pie_pkg::MAX_POINTS];
  logic signed [DW-1:0]  xa_rd_r, xb_rd_r, pa_rd_r, pb_rd_r;
  logic [pie_pkg::IDX_W-1:0] xb_addr, pb_addr;
  logic signed [PW-1:0]  t_w, d1_w, d0_w, den_w;
  logic signed [DW-1:0]  d1_r, d0_r;
  logic signed [QW-1:0]  den_r;
  logic signed [PW-1:0]  prod1_r, prod0_r;
  logic signed [NW-1:0]  diff_w;
  logic signed [PW-1:0]  num_r;
  logic                  num_sat;
  logic [PW-1:0]         dq_r;
  logic [QW-1:0]         rem_r, dabs_r;
  logic [QW:0]           rem_s;
  logic                  qneg_r, q_ge;
  logic signed [DW-1:0]  q_res;
  logic                  q_sat;
  logic                  sat_r;
  logic signed [DW-1:0]  value_r;
  pie_pkg::status_t      status_r;

  // Hold the evaluation point
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eval_point_r <= '0;
    end else if (cfg_wr) begin
      eval_point_r <= cfg_eval_point;
    end
  end

  // Point store: one write port, two registered read ports each
  assign xb_addr = cmd.idx_i - cmd.idx_j;
  assign pb_addr = cmd.idx_i - pie_pkg::IDX_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_mem[cmd.load_addr] <= in_point_x;
    end
    if (cmd.load) begin
      p_mem[cmd.load_addr] <= in_point_y;
    end else if (cmd.wr_p) begin
      p_mem[cmd.idx_i] <= q_res;
    end
    xa_rd_r <= x_mem[cmd.idx_i];
    xb_rd_r <= x_mem[xb_addr];
    pa_rd_r <= p_mem[cmd.idx_i];
    pb_rd_r <= p_mem[pb_addr];
  end

  // Differences to the evaluation point and the denominator
  assign t_w   = PW'(eval_point_r) <<< pie_pkg::FRAC_BITS;
  assign d1_w  = t_w - PW'(xb_rd_r);
  assign d0_w  = t_w - PW'(xa_rd_r);
  assign den_w = PW'(xa_rd_r) - PW'(xb_rd_r);
  assign sts.den_zero = (xa_rd_r == xb_rd_r);

  // Numerator difference, clamped to the symmetric 64-bit range
  assign diff_w  = NW'(prod1_r) - NW'(prod0_r);
  assign num_sat = (diff_w > N_MAX) || (diff_w < N_MIN);

  // One quotient bit per step
  assign rem_s = {rem_r, dq_r[PW-1]};
  assign q_ge  = (rem_s >= {1'b0, dabs_r});

  // Apply the sign and clamp the quotient
  always_comb begin
    q_sat = 1'b0;
    if (qneg_r) begin
      if (dq_r > Q_NEG) begin
        q_sat = 1'b1;
        q_res = D_MIN[DW-1:0];
      end else begin
        q_res = DW'(-dq_r);
      end
    end else begin
      if (dq_r > Q_POS) begin
        q_sat = 1'b1;
        q_res = D_MAX[DW-1:0];
      end else begin
        q_res = dq_r[DW-1:0];
      end
    end
  end

  // Arithmetic stages of one update
  always_ff @(posedge clk) begin
    if (cmd.do_sub) begin
      d1_r  <= (d1_w > D_MAX) ? D_MAX[DW-1:0] : (d1_w < D_MIN) ? D_MIN[DW-1:0] : d1_w[DW-1:0];
      d0_r  <= (d0_w > D_MAX) ? D_MAX[DW-1:0] : (d0_w < D_MIN) ? D_MIN[DW-1:0] : d0_w[DW-1:0];
      den_r <= den_w[QW-1:0];
    end
    if (cmd.do_mul) begin
      prod1_r <= PW'(d1_r) * PW'(pa_rd_r);
      prod0_r <= PW'(d0_r) * PW'(pb_rd_r);
    end
    if (cmd.do_num) begin
      num_r <= (diff_w > N_MAX) ? N_MAX[PW-1:0] :
               (diff_w < N_MIN) ? N_MIN[PW-1:0] : diff_w[PW-1:0];
    end
    if (cmd.div_load) begin
      dq_r   <= num_r[PW-1] ? PW'(-num_r) : PW'(num_r);
      dabs_r <= den_r[QW-1] ? QW'(-den_r) : QW'(den_r);
      rem_r  <= '0;
      qneg_r <= num_r[PW-1] ^ den_r[QW-1];
    end else if (cmd.div_step) begin
      rem_r <= q_ge ? QW'(rem_s - {1'b0, dabs_r}) : rem_s[QW-1:0];
      dq_r  <= {dq_r[PW-2:0], q_ge};
    end
  end

  // Track saturation over the whole evaluation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r <= 1'b0;
    end else if (cmd.clr_sat) begin
      sat_r <= 1'b0;
    end else begin
      if (cmd.do_sub && ((d1_w > D_MAX) || (d1_w < D_MIN) ||
                         (d0_w > D_MAX) || (d0_w < D_MIN))) begin
        sat_r <= 1'b1;
      end
      if (cmd.do_num && num_sat) begin
        sat_r <= 1'b1;
      end
      if (cmd.wr_p && q_sat) begin
        sat_r <= 1'b1;
      end
    end
  end

  // Capture the result item
  always_ff @(posedge clk) begin
    if (cmd.cap_out) begin
      if (cmd.out_code == pie_pkg::ST_OK) begin
        value_r  <= pa_rd_r;
        status_r <= sat_r ? pie_pkg::ST_SAT : pie_pkg::ST_OK;
      end else begin
        value_r  <= '0;
        status_r <= cmd.out_code;
      end
    end
  end

  assign out_value  = value_r;
  assign out_status = status_r;

endmodule

### rtl/pie_ctrl.sv
module pie_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tlast,
  output logic              in_tready,
  input  logic              out_tready,
  output logic              out_tvalid,
  input  pie_pkg::pie_sts_t sts,
  output pie_pkg::pie_cmd_t cmd
);

  localparam int IW = pie_pkg::IDX_W;
  localparam int CW = pie_pkg::CNT_W;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_RD   = 10'b0000000010,
    S_SUB  = 10'b0000000100,
    S_MUL  = 10'b0000001000,
    S_NUM  = 10'b0000010000,
    S_LD   = 10'b0000100000,
    S_DIV  = 10'b0001000000,
    S_WR   = 10'b0010000000,
    S_FRD  = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [CW-1:0]             cnt_r, cnt_nxt;
  logic                      ovf_r, ovf_nxt;
  logic [IW-1:0]             i_r, i_nxt, j_r, j_nxt;
  logic [pie_pkg::DCNT_W-1:0] dcnt_r, dcnt_nxt;
  pie_pkg::status_t          code_r, code_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      acc, full, out_free;
  logic [IW-1:0]             last_idx;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign acc        = in_tvalid && in_tready;
  assign full       = (cnt_r == CW'(pie_pkg::MAX_POINTS));
  assign out_free   = !out_valid_r || out_tready;
  assign last_idx   = IW'(cnt_r - CW'(1));

  // Sequence loading, the triangular recurrence and the result
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    dcnt_nxt      = dcnt_r;
    code_nxt      = code_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    cmd           = '0;
    cmd.load_addr = cnt_r[IW-1:0];
    cmd.idx_i     = i_r;
    cmd.idx_j     = j_r;
    cmd.out_code  = code_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          cmd.load = !full;
          if (!full) begin
            cnt_nxt = cnt_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_tlast) begin
            cmd.clr_sat = 1'b1;
            if (ovf_r || full) begin
              code_nxt  = pie_pkg::ST_OVF;
              state_nxt = S_DONE;
            end else if (cnt_r == '0) begin
              i_nxt     = '0;
              state_nxt = S_FRD;
            end else begin
              i_nxt     = cnt_r[IW-1:0];
              j_nxt     = IW'(1);
              state_nxt = S_RD;
            end
          end
        end
      end
      S_RD: begin
        state_nxt = S_SUB;
      end
      S_SUB: begin
        cmd.do_sub = 1'b1;
        if (sts.den_zero) begin
          code_nxt  = pie_pkg::ST_DUP;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.do_mul = 1'b1;
        state_nxt  = S_NUM;
      end
      S_NUM: begin
        cmd.do_num = 1'b1;
        state_nxt  = S_LD;
      end
      S_LD: begin
        cmd.div_load = 1'b1;
        dcnt_nxt     = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        dcnt_nxt     = dcnt_r + pie_pkg::DCNT_W'(1);
        if (dcnt_r == pie_pkg::DCNT_W'(pie_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_WR;
        end
      end
      S_WR: begin
        cmd.wr_p = 1'b1;
        if (i_r == j_r) begin
          i_nxt = last_idx;
          if (j_r == last_idx) begin
            state_nxt = S_FRD;
          end else begin
            j_nxt     = j_r + IW'(1);
            state_nxt = S_RD;
          end
        end else begin
          i_nxt     = i_r - IW'(1);
          state_nxt = S_RD;
        end
      end
      S_FRD: begin
        code_nxt  = pie_pkg::ST_OK;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.cap_out   = 1'b1;
          out_valid_nxt = 1'b1;
          cnt_nxt       = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Advance control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      dcnt_r      <= '0;
      code_r      <= pie_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      dcnt_r      <= dcnt_nxt;
      code_r      <= code_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/polynomial_interpolation_eval.sv
// Loading: one point item per cycle while idle.
// Evaluation of n points: (n-1)n/2 updates, each a read, subtract, multiply,
// numerator, divider load, bit-serial divide and write; then the result is read
// out (not on overflow) and captured; a stalled result output holds the capture.
// One data set is evaluated at a time; points are not taken during evaluation.
// Synchronous active-low reset clears control, the point count and eval_point.
module polynomial_interpolation_eval (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,     // eval_point
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,     // point_x [31:0], point_y [63:32]
  input  logic        in_tlast,     // last_point
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,    // value [31:0]
  output logic [1:0]  out_tuser     // status [1:0]
);

  pie_pkg::pie_cmd_t cmd;
  pie_pkg::pie_sts_t sts;
  logic signed [31:0] value;
  pie_pkg::status_t   status;

  assign cfg_ready = 1'b1;

  pie_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .sts        (sts),
    .cmd        (cmd)
  );

  pie_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr         (cfg_valid),
    .cfg_eval_point (cfg_data),
    .in_point_x     (in_tdata[31:0]),
    .in_point_y     (in_tdata[63:32]),
    .cmd            (cmd),
    .sts            (sts),
    .out_value      (value),
    .out_status     (status)
  );

  assign out_tdata = value;
  assign out_tuser = status;

`ifndef SYNTHESIS
  a_err_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == pie_pkg::ST_DUP || out_tuser == pie_pkg::ST_OVF)
    |-> out_tdata == 32'd0)
    else $error("error result with nonzero value");

  a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_p |-> !cmd.load)
    else $error("load and update write the store together");

  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input taken during evaluation");
`endif

endmodule

### tb/tb_top.sv
module tb_top;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;     // point_x [31:0], point_y [63:32]
  logic        in_tlast;     // last_point
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;    // value [31:0]
  logic [1:0]  out_tuser;    // status [1:0]

  polynomial_interpolation_eval dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  typedef struct packed {
    logic [31:0]      value;
    pie_pkg::status_t status;
  } interp_result_t;

  // Shadow of the block's state
  logic signed [15:0] eval_t;
  logic signed [31:0] xs [pie_pkg::MAX_POINTS];
  logic signed [31:0] ys [pie_pkg::MAX_POINTS];
  int                 n_loaded;
  bit                 store_overflow;

  interp_result_t expected_results[$];
  int  mismatches;
  bit  idle_on;
  longint items_sent;

  always #5 clk = ~clk;

  // Saturate to the 32-bit signed range
  function automatic logic signed [63:0] clip32(input logic signed [63:0] v,
                                                inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Run the triangular recurrence over the loaded points
  function automatic interp_result_t neville_eval();
    logic signed [63:0]  p [pie_pkg::MAX_POINTS];
    logic signed [63:0]  t, den, d1, d0, q;
    logic signed [127:0] num;
    interp_result_t      r;
    bit                  sat;
    sat = 0;
    t = 64'(eval_t) <<< pie_pkg::FRAC_BITS;
    for (int i = 0; i < n_loaded; i++) p[i] = 64'(ys[i]);
    for (int j = 1; j < n_loaded; j++) begin
      for (int i = n_loaded - 1; i >= j; i--) begin
        den = 64'(xs[i]) - 64'(xs[i-j]);
        if (den == 0) begin
          r.value = '0;
          r.status = pie_pkg::ST_DUP;
          return r;
        end
        d1 = clip32(t - 64'(xs[i-j]), sat);
        d0 = clip32(t - 64'(xs[i]), sat);
        num = 128'(d1 * p[i]) - 128'(d0 * p[i-1]);
        if (num > 128'sh7fffffffffffffff) begin
          sat = 1;
          num = 128'sh7fffffffffffffff;
        end else if (num < -128'sh7fffffffffffffff) begin
          sat = 1;
          num = -128'sh7fffffffffffffff;
        end
        q = 64'(num) / den;
        p[i] = clip32(q, sat);
      end
    end
    r.value = p[n_loaded-1][31:0];
    r.status = sat ? pie_pkg::ST_SAT : pie_pkg::ST_OK;
    return r;
  endfunction

  // Track one accepted point and, on the last one, queue the set's result
  function automatic void absorb_point(input logic [31:0] x, input logic [31:0] y,
                                       input bit last);
    if (n_loaded < pie_pkg::MAX_POINTS) begin
      xs[n_loaded] = x;
      ys[n_loaded] = y;
      n_loaded++;
    end else begin
      store_overflow = 1;
    end
    if (last) begin
      if (store_overflow) expected_results.push_back({32'd0, pie_pkg::ST_OVF});
      else expected_results.push_back(neville_eval());
      n_loaded = 0;
      store_overflow = 0;
    end
  endfunction

  task automatic sender_gap();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // Send one point and wait for its acceptance; valid stays up for the next one
  task automatic send_point(input logic [31:0] x, input logic [31:0] y, input bit last);
    sender_gap();
    in_tvalid <= 1'b1;
    in_tdata  <= {y, x};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    absorb_point(x, y, last);
    items_sent++;
  endtask

  // Drop valid and hold until every expected result has come
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_eval_point(input logic [15:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    eval_t = v;
  endtask

  // Q16.16 integer value with a small random fraction
  function automatic logic [31:0] rand_fix(input int span);
    int k;
    k = $urandom_range(0, 2 * span) - span;
    return (k <<< pie_pkg::FRAC_BITS) + $urandom_range(0, 3);
  endfunction

  // Send a set of n points with distinct x unless a duplicate is wanted
  task automatic send_set(input int n, input bit dup);
    logic [31:0] x;
    for (int i = 0; i < n; i++) begin
      x = (i <<< (pie_pkg::FRAC_BITS + 3)) + rand_fix(2) * 3;
      if (dup && i == n - 1 && n > 1) x = xs[0];
      send_point(x, rand_fix(50), i == n - 1);
    end
  endtask

  task automatic test_directed();
    write_eval_point(16'sd0);
    send_point(32'h7fffffff, 32'h80000000, 1);
    send_point(32'h80000000, 32'h7fffffff, 0);
    send_point(32'h7fffffff, 32'h80000000, 1);
    write_eval_point(16'sh7fff);
    send_point(32'h80000000, 32'h7fffffff, 0);
    send_point(32'h7fffffff, 32'hffffffff, 1);
    write_eval_point(16'sh8000);
    send_point(32'h00010000, 32'h7fffffff, 0);
    send_point(32'h00020000, 32'h80000000, 0);
    send_point(32'h00030000, 32'h7fffffff, 1);
    write_eval_point(16'sd2);
    send_set(3, 1);
    send_set(1, 0);
    send_set(4, 0);
  endtask

  task automatic test_overflow();
    for (int i = 0; i < pie_pkg::MAX_POINTS + 2; i++)
      send_point($urandom, $urandom, i == pie_pkg::MAX_POINTS + 1);
    send_point($urandom, $urandom, 0);
    for (int i = 1; i < pie_pkg::MAX_POINTS; i++)
      send_point(i <<< pie_pkg::FRAC_BITS, rand_fix(20), i == pie_pkg::MAX_POINTS - 1);
  endtask

  task automatic test_random();
    int r;
    idle_on = 1;
    while (items_sent < 1600) begin
      r = $urandom_range(0, 19);
      if (r == 0) write_eval_point(16'($urandom));
      else if (r == 1) write_eval_point(16'($urandom_range(0, 6) - 3));
      else if (r == 2) begin
        wait_drained();
      end else if (r == 3) send_set($urandom_range(2, 5), 1);
      else if (r == 4) send_point($urandom, $urandom, $urandom_range(0, 2) == 0);
      else send_set($urandom_range(1, 6), 0);
    end
    idle_on = 0;
    while (items_sent < 1750) send_set($urandom_range(1, 5), 0);
  endtask

  // Random backpressure on the result side
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 9) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    interp_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h/%0d", out_tdata, out_tuser);
      end else begin
        exp_r = expected_results.pop_front();
        if (out_tdata !== exp_r.value || out_tuser !== exp_r.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: value %h status %0d, expected %h status %0d",
                     out_tdata, out_tuser, exp_r.value, exp_r.status);
        end
      end
    end
  end

  initial begin
    #50000000;
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    clk = 0;
    rst_n = 0;
    cfg_valid = 0;
    cfg_data = '0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tlast = 0;
    mismatches = 0;
    idle_on = 0;
    items_sent = 0;
    eval_t = 0;
    n_loaded = 0;
    store_overflow = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_overflow();
    test_random();
    wait_drained();
    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
